// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/swps_pkg.sv
// ----------------------------------------------------------------------------
// seed word pair scorer package
// field widths, register codes and fixed constants of the scorer
// ----------------------------------------------------------------------------
package swps_pkg;

  localparam int WORD_W     = 18;
  localparam int IDX_W      = 5;
  localparam int VALUE_W    = 8;
  localparam int SCORE_W    = 10;
  localparam int THRESH_W   = 10;
  localparam int LEN_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int SCORE_MAX = 511;
  localparam int SCORE_MIN = -512;

  localparam logic signed [THRESH_W-1:0] THRESH_RESET = 10'sd11;
  localparam logic [LEN_W-1:0]           LEN_RESET    = 3'd3;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_SCORE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_WORD_LENGTH = 2'd1
  } cfg_reg_t;

endpackage

// File: hw/rtl/seed_word_pair_scorer.sv
// ----------------------------------------------------------------------------
// seed word pair scorer
// sums substitution table scores over the letters of two packed seed words
// ----------------------------------------------------------------------------
// The block takes one word per cycle while in_stall is low. A score word
// passes through one input stage, one stage per letter that splits off a
// base-ALPHABET_SIZE digit of each seed word, one table read stage
// (WORD_MAX table copies, one per letter position, read in parallel),
// one sum stage and the result register, which holds its score. A load
// word writes its entry when it reaches the table read stage and gives
// no result; words taken after it see the new entry. in_stall rises only
// when every stage holds a word and the result is stalled.
module seed_word_pair_scorer #(
  parameter int WORD_MAX      = 4,
  parameter int ALPHABET_SIZE = 20,
  parameter int ENTRY_BITS    = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_func,
  input  logic [swps_pkg::WORD_W-1:0]             in_word_a,
  input  logic [swps_pkg::WORD_W-1:0]             in_word_b,
  input  logic [swps_pkg::IDX_W-1:0]              in_table_row,
  input  logic [swps_pkg::IDX_W-1:0]              in_table_col,
  input  logic signed [swps_pkg::VALUE_W-1:0]     in_table_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [swps_pkg::SCORE_W-1:0]     out_score,
  output logic                                    out_hit,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [swps_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [swps_pkg::CFG_DATA_W-1:0]         cfg_data
);

  `include "assert_macros.svh"

  localparam int WORD_W   = swps_pkg::WORD_W;
  localparam int IDX_W    = swps_pkg::IDX_W;
  localparam int VALUE_W  = swps_pkg::VALUE_W;
  localparam int SCORE_W  = swps_pkg::SCORE_W;
  localparam int THRESH_W = swps_pkg::THRESH_W;
  localparam int LEN_W    = swps_pkg::LEN_W;

  localparam int DIG_W    = $clog2(ALPHABET_SIZE);
  localparam int DEPTH    = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SUM_W    = ENTRY_BITS + $clog2(WORD_MAX) + 1;
  localparam int RECIP_SH = WORD_W + $clog2(ALPHABET_SIZE);
  localparam int RECIP_W  = RECIP_SH;
  localparam int PROD_W   = WORD_W + RECIP_W;
  localparam int ENTRY_HI = 2 ** (ENTRY_BITS - 1) - 1;
  localparam int ENTRY_LO = -ENTRY_HI - 1;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SH + ALPHABET_SIZE - 1) / ALPHABET_SIZE);
  localparam logic [WORD_W-1:0]  A_WORD    = WORD_W'(ALPHABET_SIZE);
  localparam logic [ADDR_W-1:0]  A_ADDR    = ADDR_W'(ALPHABET_SIZE);
  localparam logic [IDX_W:0]     A_IDX     = (IDX_W + 1)'(ALPHABET_SIZE);
  localparam logic [LEN_W-1:0]   WMAX_LEN  = LEN_W'(WORD_MAX);
  localparam int                 NSTAGE    = WORD_MAX + 4;

  // configuration
  logic signed [THRESH_W-1:0] threshold_r;
  logic [LEN_W-1:0]           word_length_r;
  logic [LEN_W-1:0]           len_eff;

  // input and digit stages
  logic                       st_v_r    [0:WORD_MAX];
  logic                       st_en     [0:WORD_MAX];
  swps_pkg::func_t            st_func_r [0:WORD_MAX];
  logic [IDX_W-1:0]           st_row_r  [0:WORD_MAX];
  logic [IDX_W-1:0]           st_col_r  [0:WORD_MAX];
  logic signed [VALUE_W-1:0]  st_val_r  [0:WORD_MAX];
  logic [WORD_W-1:0]          st_wa_r   [0:WORD_MAX-1];
  logic [WORD_W-1:0]          st_wb_r   [0:WORD_MAX-1];
  logic [DIG_W-1:0]           st_da_r   [1:WORD_MAX][0:WORD_MAX-1];
  logic [DIG_W-1:0]           st_db_r   [1:WORD_MAX][0:WORD_MAX-1];

  // table stage
  logic                         m_v_r;
  logic                         m_en;
  logic                         tbl_wr_en;
  logic                         row_ok;
  logic                         col_ok;
  logic [ADDR_W-1:0]            tbl_wr_addr;
  logic signed [ENTRY_BITS-1:0] tbl_wr_data;
  logic signed [ENTRY_BITS-1:0] bank_rd [0:WORD_MAX-1];

  // sum stage
  logic                    x_v_r;
  logic                    x_en;
  logic signed [SUM_W-1:0] x_sum_r;
  logic signed [SUM_W-1:0] x_sum_nxt;

  // result stage
  logic                      out_valid_r;
  logic                      o_en;
  logic signed [SCORE_W-1:0] out_score_r;
  logic signed [SCORE_W-1:0] out_score_nxt;
  logic                      out_hit_r;
  logic                      out_hit_nxt;

  logic [NSTAGE-1:0] pipe_full;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= swps_pkg::THRESH_RESET;
      word_length_r <= swps_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swps_pkg::REG_THRESHOLD:   threshold_r   <= cfg_data[THRESH_W-1:0];
        swps_pkg::REG_WORD_LENGTH: word_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (word_length_r > WMAX_LEN) ? WMAX_LEN : word_length_r;

  // advance chain, a stage moves when it is empty or the next one moves
  assign o_en = !out_valid_r || !out_stall;
  assign x_en = !x_v_r || o_en;
  assign m_en = !m_v_r || x_en;

  always_comb begin
    st_en[WORD_MAX] = !st_v_r[WORD_MAX] || m_en;
    for (int j = WORD_MAX - 1; j >= 0; j--) begin
      st_en[j] = !st_v_r[j] || st_en[j+1];
    end
  end

  assign in_stall = !st_en[0];

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r[0] <= 1'b0;
    end else if (st_en[0]) begin
      st_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_en[0]) begin
      st_func_r[0] <= swps_pkg::func_t'(in_func);
      st_row_r[0]  <= in_table_row;
      st_col_r[0]  <= in_table_col;
      st_val_r[0]  <= in_table_value;
      st_wa_r[0]   <= in_word_a;
      st_wb_r[0]   <= in_word_b;
    end
  end

  // digit stages, one letter of each word per stage
  for (genvar j = 1; j <= WORD_MAX; j++) begin : g_digit
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
    logic [WORD_W-1:0] quot_a;
    logic [WORD_W-1:0] quot_b;
    logic [WORD_W-1:0] rem_a;
    logic [WORD_W-1:0] rem_b;

    // quotient by reciprocal multiply, exact over the whole word range
    always_comb begin
      prod_a = PROD_W'(st_wa_r[j-1]) * PROD_W'(RECIP);
      prod_b = PROD_W'(st_wb_r[j-1]) * PROD_W'(RECIP);
      quot_a = prod_a[RECIP_SH +: WORD_W];
      quot_b = prod_b[RECIP_SH +: WORD_W];
      rem_a  = st_wa_r[j-1] - quot_a * A_WORD;
      rem_b  = st_wb_r[j-1] - quot_b * A_WORD;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[j] <= 1'b0;
      end else if (st_en[j]) begin
        st_v_r[j] <= st_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_en[j]) begin
        st_func_r[j]     <= st_func_r[j-1];
        st_row_r[j]      <= st_row_r[j-1];
        st_col_r[j]      <= st_col_r[j-1];
        st_val_r[j]      <= st_val_r[j-1];
        st_da_r[j][j-1]  <= rem_a[DIG_W-1:0];
        st_db_r[j][j-1]  <= rem_b[DIG_W-1:0];
      end
    end

    if (j < WORD_MAX) begin : g_word
      always_ff @(posedge clk) begin
        if (st_en[j]) begin
          st_wa_r[j] <= quot_a;
          st_wb_r[j] <= quot_b;
        end
      end
    end

    for (genvar k = 0; k < j - 1; k++) begin : g_copy
      always_ff @(posedge clk) begin
        if (st_en[j]) begin
          st_da_r[j][k] <= st_da_r[j-1][k];
          st_db_r[j][k] <= st_db_r[j-1][k];
        end
      end
    end
  end

  // table stage: loads write every copy, scores read one copy per letter
  assign row_ok = {1'b0, st_row_r[WORD_MAX]} < A_IDX;
  assign col_ok = {1'b0, st_col_r[WORD_MAX]} < A_IDX;

  assign tbl_wr_en = m_en && st_v_r[WORD_MAX] &&
                     (st_func_r[WORD_MAX] == swps_pkg::FUNC_LOAD) && row_ok && col_ok;
  assign tbl_wr_addr = ADDR_W'(st_row_r[WORD_MAX]) * A_ADDR + ADDR_W'(st_col_r[WORD_MAX]);

  always_comb begin
    if (int'(st_val_r[WORD_MAX]) > ENTRY_HI) begin
      tbl_wr_data = ENTRY_BITS'(ENTRY_HI);
    end else if (int'(st_val_r[WORD_MAX]) < ENTRY_LO) begin
      tbl_wr_data = ENTRY_BITS'(ENTRY_LO);
    end else begin
      tbl_wr_data = ENTRY_BITS'(st_val_r[WORD_MAX]);
    end
  end

  for (genvar k = 0; k < WORD_MAX; k++) begin : g_bank
    logic [ADDR_W-1:0] rd_addr;

    assign rd_addr = ADDR_W'(st_da_r[WORD_MAX][k]) * A_ADDR + ADDR_W'(st_db_r[WORD_MAX][k]);

    swps_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_BITS)
    ) u_bank (
      .clk     (clk),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (m_en),
      .rd_addr (rd_addr),
      .rd_data (bank_rd[k])
    );
  end

  // load words end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_en) begin
      m_v_r <= st_v_r[WORD_MAX] && (st_func_r[WORD_MAX] == swps_pkg::FUNC_SCORE);
    end
  end

  // sum stage, letters past the word length add nothing
  always_comb begin
    x_sum_nxt = '0;
    for (int k = 0; k < WORD_MAX; k++) begin
      if (LEN_W'(k) < len_eff) begin
        x_sum_nxt = x_sum_nxt + SUM_W'(bank_rd[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else if (x_en) begin
      x_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (x_en) begin
      x_sum_r <= x_sum_nxt;
    end
  end

  // result stage: saturate and compare
  always_comb begin
    if (int'(x_sum_r) > swps_pkg::SCORE_MAX) begin
      out_score_nxt = SCORE_W'(swps_pkg::SCORE_MAX);
    end else if (int'(x_sum_r) < swps_pkg::SCORE_MIN) begin
      out_score_nxt = SCORE_W'(swps_pkg::SCORE_MIN);
    end else begin
      out_score_nxt = SCORE_W'(x_sum_r);
    end
    out_hit_nxt = out_score_nxt >= threshold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_en) begin
      out_valid_r <= x_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      out_score_r <= out_score_nxt;
      out_hit_r   <= out_hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;
  assign out_hit   = out_hit_r;

  // occupancy of every stage
  always_comb begin
    for (int j = 0; j <= WORD_MAX; j++) begin
      pipe_full[j] = st_v_r[j];
    end
    pipe_full[WORD_MAX+1] = m_v_r;
    pipe_full[WORD_MAX+2] = x_v_r;
    pipe_full[WORD_MAX+3] = out_valid_r;
  end

  `ASSERT_IMPL(a_stall_only_full, in_stall, &pipe_full, "input stalled with a bubble in the pipe")
  `ASSERT_NEXT(a_load_dropped, m_en && st_v_r[WORD_MAX] && (st_func_r[WORD_MAX] == swps_pkg::FUNC_LOAD), !m_v_r, "load word passed the table stage")
  `ASSERT_NEXT(a_score_kept, m_en && st_v_r[WORD_MAX] && (st_func_r[WORD_MAX] == swps_pkg::FUNC_SCORE), m_v_r, "score word lost at the table stage")
  `ASSERT_ALWAYS(a_single_write, !(tbl_wr_en && !st_v_r[WORD_MAX]), "table written without a load word")

endmodule

// File: hw/rtl/swps_bank.sv
// ----------------------------------------------------------------------------
// substitution table bank
// one copy of the score table, one write port and one registered read port
// ----------------------------------------------------------------------------
module swps_bank #(
  parameter int DEPTH  = 400,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
